FILE: hw/rtl/tmo_pkg.sv
// shared types and constants for the multi-slot timeout manager
`timescale 1ns / 1ps

package tmo_pkg;

	localparam int SLOTS   = 16;
	localparam int COUNT_W = 32;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int REM_W   = COUNT_W + 1;

	localparam int CMD_W  = 2;
	localparam int SLOT_W = 4;
	localparam int DUR_W  = 31;
	localparam int TICK_W = 32;
	localparam int TPM_W  = 16;
	localparam int PROD_W = DUR_W + TPM_W;

	localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1);

	localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_CANCEL  = 2'd1,
		KIND_EXPIRED = 2'd2,
		KIND_DONE    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_FIN,
		ST_DONE
	} state_t;

	// contents of one slot cell
	typedef struct packed {
		logic               armed;
		logic [REM_W-1:0]   rem;
		logic [COUNT_W-1:0] seen;
		logic [COUNT_W-1:0] el;
	} cell_t;

	// controls broadcast to every cell
	typedef struct packed {
		logic               shift;
		logic               prep;
		logic [COUNT_W-1:0] now;
	} cell_ctl_t;

	// per-cell write request from start or cancel
	typedef struct packed {
		logic               set;
		logic               clr;
		logic [COUNT_W-1:0] t;
		logic [COUNT_W-1:0] now;
	} cell_wr_t;

endpackage

FILE: hw/rtl/tmo_if.sv
// request and response channel interfaces of the timeout manager
`timescale 1ns / 1ps

interface tmo_in_if;
	import tmo_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [SLOT_W-1:0]   slot;
	logic [DUR_W-1:0]    duration_ms;
	logic [TICK_W-1:0]   cur_count;

	modport source (output valid, output cmd, output slot, output duration_ms,
		output cur_count, input ready);
	modport sink (input valid, input cmd, input slot, input duration_ms,
		input cur_count, output ready);
endinterface

interface tmo_out_if;
	import tmo_pkg::*;

	logic                valid;
	logic                ready;
	kind_t               kind;
	logic [SLOT_W-1:0]   slot_out;
	logic                was_armed;
	logic [TICK_W-1:0]   next_compare;
	logic                last;

	modport source (output valid, output kind, output slot_out, output was_armed,
		output next_compare, output last, input ready);
	modport sink (input valid, input kind, input slot_out, input was_armed,
		input next_compare, input last, output ready);
endinterface

FILE: hw/rtl/tmo_cell.sv
// one timeout slot cell of the rotating ring
`timescale 1ns / 1ps

module tmo_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  tmo_pkg::cell_ctl_t ctl,
	input  tmo_pkg::cell_wr_t  wr,
	input  tmo_pkg::cell_t     nbr,
	output tmo_pkg::cell_t     q
);
	import tmo_pkg::*;

	logic               armed_q;
	logic [REM_W-1:0]   rem_q;
	logic [COUNT_W-1:0] seen_q;
	logic [COUNT_W-1:0] el_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (ctl.shift) begin
			armed_q <= nbr.armed;
		end else if (wr.set) begin
			armed_q <= 1'b1;
		end else if (wr.clr) begin
			armed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			rem_q  <= nbr.rem;
			seen_q <= nbr.seen;
			el_q   <= nbr.el;
		end else if (wr.set) begin
			rem_q  <= {1'b0, wr.t};
			seen_q <= wr.now;
		end else if (ctl.prep) begin
			// wrapped elapsed time since this slot was last seen
			el_q <= ctl.now - seen_q;
		end
	end

	assign q = '{armed: armed_q, rem: rem_q, seen: seen_q, el: el_q};

endmodule

FILE: hw/rtl/tmo_head.sv
// expiry evaluation at the head of the cell ring
`timescale 1ns / 1ps

module tmo_head (
	input  tmo_pkg::cell_t                c,
	input  logic [tmo_pkg::COUNT_W-1:0]   now,
	output tmo_pkg::cell_t                nxt,
	output logic                          expired,
	output logic                          live,
	output logic [tmo_pkg::COUNT_W-1:0]   cand
);
	import tmo_pkg::*;

	logic [REM_W-1:0] new_rem;

	always_comb begin
		new_rem = c.rem - {1'b0, c.el};
		// zero or negative remaining time
		expired = c.armed && (new_rem[REM_W-1] || (new_rem == '0));
		live    = c.armed && !expired;
		cand    = live ? new_rem[COUNT_W-1:0] : '1;

		nxt.armed = live;
		nxt.rem   = c.armed ? new_rem : c.rem;
		nxt.seen  = live ? now : c.seen;
		nxt.el    = c.el;
	end

endmodule

FILE: hw/rtl/multi_slot_timeout_manager.sv
// top level of the multi-slot one-shot timeout manager
// cancel result is registered straight from its transaction, a start result from ST_START
// check: one slot per cycle passes the head of the cell ring, then ST_FIN and ST_DONE;
// expired results come out as their slot reaches the head; output stalls hold the ring
// throughput: one item at a time; the next transaction is taken after the final result
// reset: arst_n clears every armed bit, sets the compare value to all ones, ticks_per_ms to 1
`timescale 1ns / 1ps

module multi_slot_timeout_manager (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tmo_pkg::TPM_W-1:0]  cfg_wdata,
	tmo_in_if.sink                     in_ch,
	tmo_out_if.source                  out_ch
);
	import tmo_pkg::*;

	// control
	state_t state_q, state_d;
	logic   in_acc;
	logic   in_rdy;
	logic   out_free;
	logic   step;
	logic   start_wr;
	logic   cancel_wr;
	logic   last_step;

	// held item fields and configuration
	logic [TPM_W-1:0]   tpm_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COUNT_W-1:0] now_q;
	logic [PROD_W-1:0]  prod_q;
	logic [IDX_W-1:0]   cnt_q;

	// compare value and scan minimum
	logic [COUNT_W-1:0] compare_q, cmp_d;
	logic [COUNT_W-1:0] min_q;
	logic [COUNT_W-1:0] cand_s1;
	logic               any_q;

	// start path
	logic [COUNT_W-1:0] t_sat;
	logic [COUNT_W-1:0] deadline;
	logic [COUNT_W-1:0] start_cmp;
	logic [COUNT_W-1:0] final_cmp;
	logic               slot_ok;

	// cell ring
	cell_t              cell_q [SLOTS];
	cell_wr_t           wr [SLOTS];
	cell_ctl_t          ctl;
	logic [SLOTS-1:0]   hit_c;
	logic [SLOTS-1:0]   armed_vec;
	logic               was_armed;
	cell_t              head_nxt;
	logic               head_exp;
	logic               head_live;
	logic [COUNT_W-1:0] head_cand;

	// output register
	logic               out_v_q;
	kind_t              out_kind_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_was_q;
	logic [TICK_W-1:0]  out_cmp_q;
	logic               out_last_q;

	logic               ld;
	kind_t              o_kind;
	logic [SLOT_W-1:0]  o_slot;
	logic               o_was;
	logic [COUNT_W-1:0] o_cmp;
	logic               o_last;

	assign out_free  = !out_v_q || out_ch.ready;
	assign in_acc    = in_ch.valid && in_rdy;
	assign in_ch.ready = in_rdy;
	assign last_step = (cnt_q == IDX_W'(SLOTS - 1));

	// duration times ticks_per_ms, saturated to the counter range
	assign t_sat     = (|prod_q[PROD_W-1:COUNT_W]) ? '1 : prod_q[COUNT_W-1:0];
	assign deadline  = now_q + t_sat;
	assign slot_ok   = (32'(slot_q) < 32'(SLOTS));
	assign start_cmp = (slot_ok && (deadline < compare_q)) ? deadline : compare_q;
	assign final_cmp = any_q ? (now_q + min_q) : '1;

	// ring of cells: cell 0 feeds the head, the head refills the far end
	assign ctl.shift = step;
	assign ctl.prep  = in_acc && (in_ch.cmd == CMD_CHECK);
	assign ctl.now   = in_ch.cur_count[COUNT_W-1:0];

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cell_t nbr;

		assign hit_c[i]     = (32'(in_ch.slot) == 32'(i));
		assign armed_vec[i] = cell_q[i].armed;
		assign wr[i].set    = start_wr && (32'(slot_q) == 32'(i));
		assign wr[i].clr    = cancel_wr && hit_c[i];
		assign wr[i].t      = t_sat;
		assign wr[i].now    = now_q;

		if (i == SLOTS - 1) begin : g_tail
			assign nbr = head_nxt;
		end else begin : g_mid
			assign nbr = cell_q[i+1];
		end

		tmo_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.wr     (wr[i]),
			.nbr    (nbr),
			.q      (cell_q[i])
		);
	end

	assign was_armed = |(hit_c & armed_vec);

	tmo_head u_head (
		.c       (cell_q[0]),
		.now     (now_q),
		.nxt     (head_nxt),
		.expired (head_exp),
		.live    (head_live),
		.cand    (head_cand)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_ch.cmd)
						CMD_START: state_d = ST_START;
						CMD_CHECK: state_d = ST_SCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_START: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (out_free && last_step) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_rdy    = 1'b0;
		ld        = 1'b0;
		step      = 1'b0;
		start_wr  = 1'b0;
		cancel_wr = 1'b0;
		cmp_d     = compare_q;
		o_kind    = KIND_START;
		o_slot    = '0;
		o_was     = 1'b0;
		o_cmp     = compare_q;
		o_last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = out_free;
				if (in_acc && (in_ch.cmd == CMD_CANCEL)) begin
					ld        = 1'b1;
					cancel_wr = 1'b1;
					o_kind    = KIND_CANCEL;
					o_slot    = in_ch.slot;
					o_was     = was_armed;
					o_last    = 1'b1;
				end
			end
			ST_START: begin
				if (out_free) begin
					ld       = 1'b1;
					start_wr = slot_ok;
					cmp_d    = start_cmp;
					o_kind   = KIND_START;
					o_slot   = slot_q;
					o_cmp    = start_cmp;
					o_last   = 1'b1;
				end
			end
			ST_SCAN: begin
				step = out_free;
				if (out_free && head_exp) begin
					ld     = 1'b1;
					o_kind = KIND_EXPIRED;
					o_slot = SLOT_W'(cnt_q);
				end
			end
			ST_FIN: begin
				ld = 1'b0;
			end
			ST_DONE: begin
				if (out_free) begin
					ld     = 1'b1;
					cmp_d  = final_cmp;
					o_kind = KIND_DONE;
					o_cmp  = final_cmp;
					o_last = 1'b1;
				end
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tpm_q     <= TPM_RESET;
			compare_q <= '1;
			cnt_q     <= '0;
			any_q     <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			compare_q <= cmp_d;
			if (cfg_we) tpm_q <= cfg_wdata;
			if (in_acc) begin
				cnt_q <= '0;
				any_q <= 1'b0;
			end else if (step) begin
				cnt_q <= cnt_q + IDX_W'(1);
				any_q <= any_q | head_live;
			end
			if (ld) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// item fields, scan minimum and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_q <= in_ch.slot;
			now_q  <= in_ch.cur_count[COUNT_W-1:0];
			prod_q <= PROD_W'(in_ch.duration_ms) * PROD_W'(tpm_q);
		end
		// candidate is registered, folded into the minimum in the next cycle
		cand_s1 <= (step && head_live) ? head_cand : '1;
		if (in_acc) begin
			min_q <= '1;
		end else if (((state_q == ST_SCAN) || (state_q == ST_FIN)) && (cand_s1 < min_q)) begin
			min_q <= cand_s1;
		end
		if (ld) begin
			out_kind_q <= o_kind;
			out_slot_q <= o_slot;
			out_was_q  <= o_was;
			out_cmp_q  <= TICK_W'(o_cmp);
			out_last_q <= o_last;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.kind         = out_kind_q;
	assign out_ch.slot_out     = out_slot_q;
	assign out_ch.was_armed    = out_was_q;
	assign out_ch.next_compare = out_cmp_q;
	assign out_ch.last         = out_last_q;

endmodule

FILE: hw/rtl/tmo_check.sv
// port-level assertions for the timeout manager and their bind
`timescale 1ns / 1ps

module tmo_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input tmo_pkg::kind_t              out_kind,
	input logic [tmo_pkg::SLOT_W-1:0]  out_slot,
	input logic                        out_was,
	input logic [tmo_pkg::TICK_W-1:0]  out_cmp,
	input logic                        out_last
);
	import tmo_pkg::*;

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_slot)
			&& $stable(out_was) && $stable(out_cmp) && $stable(out_last))
		else $error("result changed while stalled");

	// start and cancel answer with a single result
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_START || out_kind == KIND_CANCEL) |-> out_last)
		else $error("start or cancel result not marked last");

	// an expired slot is never the closing result of a check
	a_exp_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_EXPIRED |-> !out_last)
		else $error("expired result marked last");

	// was_armed only on cancel results
	a_was_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_CANCEL |-> !out_was)
		else $error("was_armed set outside cancel");

	// check done reports slot zero
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_DONE |-> out_slot == '0)
		else $error("check done with nonzero slot");

endmodule

bind multi_slot_timeout_manager tmo_check u_tmo_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_kind  (out_ch.kind),
	.out_slot  (out_ch.slot_out),
	.out_was   (out_ch.was_armed),
	.out_cmp   (out_ch.next_compare),
	.out_last  (out_ch.last)
);

FILE: verif/tb.sv
// self-checking testbench for the multi-slot timeout manager
`timescale 1ns / 1ps

module tb;
	import tmo_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = SLOTS + 8;
	localparam int PHASE_ITEMS  = 48;

	// one expected output transaction
	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic                armed;
		logic [TICK_W-1:0]   cmp;
		logic                last;
	} slot_report_t;

	// tracks the slot bank and the compare register, queues the reports each command causes
	class deadline_tracker;
		logic [TPM_W-1:0]          rate;
		bit                        armed [SLOTS];
		bit signed [REM_W-1:0]     left [SLOTS];
		bit [COUNT_W-1:0]          seen [SLOTS];
		bit [COUNT_W-1:0]          cmp;
		slot_report_t              reports_due [$];
		int                        fails;

		function new();
			rate  = TPM_RESET;
			cmp   = '1;
			fails = 0;
			foreach (armed[i]) armed[i] = 1'b0;
		endfunction

		function void note(kind_t k, logic [SLOT_W-1:0] s, logic a, logic l);
			slot_report_t r;
			r = '{k, s, a, cmp, l};
			reports_due.push_back(r);
		endfunction

		function void take_command(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
				logic [DUR_W-1:0] d, logic [TICK_W-1:0] n);
			logic [PROD_W-1:0]     prod;
			logic [COUNT_W-1:0]    t;
			logic [COUNT_W-1:0]    deadline;
			logic [COUNT_W-1:0]    el;
			logic [COUNT_W-1:0]    least;
			bit                    any;
			bit signed [REM_W-1:0] r;
			case (c)
				CMD_START: begin
					prod = d * rate;
					t = (prod > PROD_W'({COUNT_W{1'b1}})) ? '1 : prod[COUNT_W-1:0];
					left[s]  = {1'b0, t};
					seen[s]  = n;
					armed[s] = 1'b1;
					deadline = n + t;
					if (deadline < cmp)
						cmp = deadline;
					note(KIND_START, s, 1'b0, 1'b1);
				end
				CMD_CANCEL: begin
					note(KIND_CANCEL, s, armed[s], 1'b1);
					armed[s] = 1'b0;
				end
				CMD_CHECK: begin
					least = '1;
					any   = 1'b0;
					for (int i = 0; i < SLOTS; i++) begin
						if (armed[i]) begin
							el = n - seen[i];
							r  = left[i] - $signed({1'b0, el});
							left[i] = r;
							if (r <= 0) begin
								armed[i] = 1'b0;
								note(KIND_EXPIRED, SLOT_W'(i), 1'b0, 1'b0);
							end else begin
								if (r[COUNT_W-1:0] < least)
									least = r[COUNT_W-1:0];
								seen[i] = n;
								any = 1'b1;
							end
						end
					end
					cmp = any ? n + least : '1;
					note(KIND_DONE, '0, 1'b0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void match(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", field, want, got);
				fails++;
			end
		endfunction

		function void check_report(logic [1:0] k, logic [SLOT_W-1:0] s, logic a,
				logic [TICK_W-1:0] c, logic l);
			slot_report_t w;
			if (reports_due.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d", k, s);
				fails++;
				return;
			end
			w = reports_due.pop_front();
			match("kind", w.kind, k);
			match("slot_out", w.slot, s);
			match("was_armed", w.armed, a);
			match("next_compare", w.cmp, c);
			match("last", w.last, l);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [TPM_W-1:0] cfg_wdata;

	tmo_in_if  in_ch ();
	tmo_out_if out_ch ();

	multi_slot_timeout_manager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	deadline_tracker tracker = new();

	int               idle_pct  = 0;
	int               stall_pct = 0;
	int               cycles    = 0;
	logic [TICK_W-1:0] now_cursor;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: check each accepted transaction, then pick ready for the next edge
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			tracker.check_report(out_ch.kind, out_ch.slot_out, out_ch.was_armed,
				out_ch.next_compare, out_ch.last);
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// present one command and hold it until the block takes it
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [DUR_W-1:0] d, input logic [TICK_W-1:0] n);
		// random sender gap before the item; valid only ever gets one update per edge
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.cmd         <= c;
		in_ch.slot        <= s;
		in_ch.duration_ms <= d;
		in_ch.cur_count   <= n;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		tracker.take_command(c, s, d, n);
	endtask

	// let every queued report come out, then give an ignored command time to pass through
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (tracker.reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// ticks_per_ms update, only while the block is idle
	task automatic write_rate(input logic [TPM_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.rate = v;
	endtask

	// random traffic: the counter mostly creeps forward so slots expire in step with
	// their durations, with restarts, cancels, zero and huge durations and counter jumps
	task automatic run_random(input int count);
		int                 done_items;
		int                 roll;
		logic [CMD_W-1:0]   c;
		logic [DUR_W-1:0]   d;
		logic [TICK_W-1:0]  span;
		done_items = 0;
		span = ((tracker.rate == 0) ? 32'd1 : TICK_W'(tracker.rate)) * 32'd48;
		while (done_items < count) begin
			roll = $urandom_range(99);
			if (roll < 40)
				c = CMD_START;
			else if (roll < 55)
				c = CMD_CANCEL;
			else if (roll < 95)
				c = CMD_CHECK;
			else
				c = 2'd3; // undefined command, the block drops it
			roll = $urandom_range(99);
			if (roll < 70)
				d = DUR_W'($urandom_range(64, 1));
			else if (roll < 78)
				d = '0;
			else if (roll < 93)
				d = DUR_W'($urandom());
			else
				d = '1;
			roll = $urandom_range(99);
			if (roll < 65)
				now_cursor = now_cursor + $urandom_range(span, 0);
			else if (roll < 92 && roll >= 80)
				now_cursor = now_cursor + $urandom_range(span * 8, span);
			else if (roll >= 92)
				now_cursor = $urandom();
			send_item(c, SLOT_W'($urandom_range(SLOTS - 1)), d, now_cursor);
			if (c != 2'd3)
				done_items++;
		end
	endtask

	logic [TPM_W-1:0] rates [8];

	initial begin
		in_ch.valid       <= 1'b0;
		in_ch.cmd         <= CMD_START;
		in_ch.slot        <= '0;
		in_ch.duration_ms <= '0;
		in_ch.cur_count   <= '0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= TPM_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset rate, no idling
		// cancel on a slot that was never armed
		send_item(CMD_CANCEL, 4'd7, '0, 32'd0);
		// arm every slot: zero duration on slot 0, the largest duration on the top slot
		for (int i = 0; i < SLOTS; i++)
			send_item(CMD_START, SLOT_W'(i), (i == SLOTS - 1) ? '1 : DUR_W'(i), 32'd100);
		// counter far ahead: every slot expires in one check
		send_item(CMD_CHECK, '0, '0, 32'hFFFF_FFF0);
		// zero duration checked at the same counter value
		send_item(CMD_START, 4'd2, '0, 32'd50);
		send_item(CMD_CHECK, '0, '0, 32'd50);
		// deadline past the wrap, then a restart of the armed slot
		send_item(CMD_START, 4'd7, 31'd10, 32'hFFFF_FFFA);
		send_item(CMD_START, 4'd7, 31'd3, 32'hFFFF_FFFA);
		// cancel on an armed slot
		send_item(CMD_START, 4'd9, 31'd1, 32'd0);
		send_item(CMD_CANCEL, 4'd9, '0, 32'd0);
		// check after the counter wrapped: slot 7 runs out
		send_item(CMD_CHECK, '0, '0, 32'h0000_0010);
		settle();

		// random phases: each with a rate from the list and one of four idling and stall patterns
		rates = '{16'hFFFF, 16'd1, 16'd0, 16'd1000, 16'd3, 16'd250, 16'hFFFF, 16'd17};
		rates[5] = TPM_W'($urandom_range(65535, 2));
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			write_rate(rates[p]);
			now_cursor = $urandom();
			run_random(PHASE_ITEMS);
			settle();
		end

		if (tracker.fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
